[rtl/highlight_fill_filter_defines.svh]
// Assertion macros for the highlight fill filter.
// Included by the top level; the macros expect aclk and aresetn in scope.
`ifndef HIGHLIGHT_FILL_FILTER_DEFINES_SVH
`define HIGHLIGHT_FILL_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HFF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hff_pkg.sv]
// Shared constants and types for the highlight fill filter.
// No dependencies; imported by every module of the block.
package hff_pkg;

    localparam int DEF_MAX_COLS = 512;
    localparam int DEF_MAX_ROWS = 512;
    localparam int MIN_DIM      = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int DIM_CFG_W  = 10;
    localparam int PIX_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT_LEVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_BIAS       = 2'd3;

    localparam logic [DIM_CFG_W-1:0] RST_FRAME_COLS      = 10'd512;
    localparam logic [DIM_CFG_W-1:0] RST_FRAME_ROWS      = 10'd512;
    localparam logic [PIX_W-1:0]     RST_HIGHLIGHT_LEVEL = 8'd200;
    localparam logic [PIX_W-1:0]     RST_FILL_BIAS       = 8'd190;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic [PIX_W-1:0] bias;
    } hff_thr_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hff_pass_stat_t;

endpackage

[rtl/hff_store.sv]
// Frame store: single-port-write, single-port-read synchronous memory.
// Read data is registered and holds while no read is requested. Uses hff_pkg.
module hff_store
    import hff_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_COLS * DEF_MAX_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [PIX_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [PIX_W-1:0]  rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hff_div.sv]
// Restoring divider, one quotient bit per cycle.
// Uses hff_pkg for the status type.
module hff_div
    import hff_pkg::*;
#(
    parameter int N_W = 26,
    parameter int D_W = 18
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output hff_pass_stat_t stat,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W:0]     rem_reg, rem_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   div_reg, div_next;
    logic [D_W:0]     rem_sh;
    logic             qbit;

    always_comb begin
        rem_sh = {rem_reg[D_W-1:0], quo_reg[N_W-1]};
        qbit   = (rem_sh >= {1'b0, div_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = qbit ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            quo_next = {quo_reg[N_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

[rtl/hff_pass.sv]
// In-place fill pass sequencer: qualification scan, window search, border clear.
// Drives the frame store through a read-modify-write port; uses hff_pkg and hff_div.
module hff_pass
    import hff_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int X_W      = $clog2(MAX_COLS + 1),
    parameter int Y_W      = $clog2(MAX_ROWS + 1),
    parameter int ADDR_W   = $clog2(MAX_COLS * MAX_ROWS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [X_W-1:0]    cols,
    input  logic [Y_W-1:0]    rows,
    input  hff_thr_t          thr,
    output hff_pass_stat_t    stat,
    output logic              mem_we,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_addr,
    output logic [PIX_W-1:0]  mem_wdata,
    input  logic [PIX_W-1:0]  mem_rdata
);

    localparam int S_W   = $clog2(MAX_COLS + MAX_ROWS + 4) + 2;
    localparam int CNT_W = $clog2(MAX_COLS * MAX_ROWS + 2);
    localparam int SUM_W = CNT_W + PIX_W;
    localparam int P_W   = X_W + Y_W;

    localparam logic [3:0] P_IDLE     = 4'd0;
    localparam logic [3:0] P_CNT_RD   = 4'd1;
    localparam logic [3:0] P_CNT_CHK  = 4'd2;
    localparam logic [3:0] P_SCAN_RD  = 4'd3;
    localparam logic [3:0] P_SCAN_CHK = 4'd4;
    localparam logic [3:0] P_WIN_RD   = 4'd5;
    localparam logic [3:0] P_WIN_ACC  = 4'd6;
    localparam logic [3:0] P_DIV      = 4'd7;
    localparam logic [3:0] P_DIV_WAIT = 4'd8;
    localparam logic [3:0] P_WR       = 4'd9;
    localparam logic [3:0] P_BORDER   = 4'd10;

    logic [3:0]              state_reg, state_next;
    logic                    done_reg, done_next;
    logic [X_W-1:0]          pc_reg, pc_next;
    logic [Y_W-1:0]          pr_reg, pr_next;
    logic [X_W-1:0]          x_reg, x_next;
    logic [Y_W-1:0]          y_reg, y_next;
    logic signed [S_W-1:0]   r_reg, r_next;
    logic signed [S_W-1:0]   a_reg, a_next;
    logic signed [S_W-1:0]   b_reg, b_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    qual_reg, qual_next;
    logic [PIX_W-1:0]        val_reg, val_next;

    logic signed [S_W-1:0]   y_s, x_s, pc_s, pr_s, cy, cx, a_abs, r2, lim;
    logic                    inb, r_is1, ring_row, row_end, win_last, hit;
    logic [CNT_W-1:0]        cnt_eff;
    logic [SUM_W-1:0]        sum_eff;
    logic [Y_W-1:0]          ay;
    logic [X_W-1:0]          ax;
    logic [P_W-1:0]          prod;
    logic                    int_last;
    logic [X_W-1:0]          int_x;
    logic [Y_W-1:0]          int_y;
    logic                    brd_last;
    logic                    div_start;
    hff_pass_stat_t          div_stat;
    logic [SUM_W-1:0]        quo;

    hff_div #(
        .N_W(SUM_W),
        .D_W(CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(sum_reg + SUM_W'(thr.bias)),
        .divisor (cnt_reg + 1'b1),
        .stat    (div_stat),
        .quotient(quo)
    );

    always_comb begin
        y_s   = S_W'(y_reg);
        x_s   = S_W'(x_reg);
        pc_s  = S_W'(pc_reg);
        pr_s  = S_W'(pr_reg);
        cy    = y_s + a_reg;
        cx    = x_s + b_reg;
        inb   = (cy >= 1) && (cy <= pr_s - 1) && (cx >= 1) && (cx <= pc_s - 1);
        r_is1 = (r_reg == 1);
        a_abs = (a_reg < 0) ? -a_reg : a_reg;
        ring_row = r_is1 || (a_abs >= r_reg - 1);
        row_end  = (b_reg == r_reg);
        win_last = row_end && (a_reg == r_reg);
        r2    = r_reg + S_W'(2);
        lim   = pr_s + pc_s + S_W'(2);
        hit   = (state_reg == P_WIN_ACC) && (mem_rdata <= thr.level);
        cnt_eff = cnt_reg + CNT_W'(hit);
        sum_eff = sum_reg + (hit ? SUM_W'(mem_rdata) : '0);

        int_last = (y_reg == pr_reg - 1'b1) && (x_reg == pc_reg - 1'b1);
        int_x    = (x_reg == pc_reg - 1'b1) ? X_W'(1) : x_reg + 1'b1;
        int_y    = (x_reg == pc_reg - 1'b1) ? y_reg + 1'b1 : y_reg;
        brd_last = int_last;

        if (state_reg == P_WIN_RD) begin
            ay = cy[Y_W-1:0];
            ax = cx[X_W-1:0];
        end else begin
            ay = y_reg;
            ax = x_reg;
        end
        prod     = {{X_W{1'b0}}, ay} * {{Y_W{1'b0}}, pc_reg} + P_W'(ax);
        mem_addr = prod[ADDR_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        pc_next    = pc_reg;
        pr_next    = pr_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        r_next     = r_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        qual_next  = qual_reg;
        val_next   = val_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wdata  = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            P_IDLE: begin
                if (start) begin
                    pc_next    = cols;
                    pr_next    = rows;
                    x_next     = X_W'(1);
                    y_next     = Y_W'(1);
                    qual_next  = 1'b0;
                    state_next = P_CNT_RD;
                end
            end
            P_CNT_RD: begin
                mem_re     = 1'b1;
                state_next = P_CNT_CHK;
            end
            P_CNT_CHK: begin
                if (mem_rdata <= thr.level) begin
                    qual_next = 1'b1;
                end
                if (int_last) begin
                    x_next     = X_W'(1);
                    y_next     = Y_W'(1);
                    state_next = P_SCAN_RD;
                end else begin
                    x_next     = int_x;
                    y_next     = int_y;
                    state_next = P_CNT_RD;
                end
            end
            P_SCAN_RD: begin
                mem_re     = 1'b1;
                state_next = P_SCAN_CHK;
            end
            P_SCAN_CHK: begin
                if (mem_rdata > thr.level) begin
                    if (!qual_reg) begin
                        val_next   = thr.bias;
                        state_next = P_WR;
                    end else begin
                        r_next     = S_W'(1);
                        a_next     = -S_W'(1);
                        b_next     = -S_W'(1);
                        sum_next   = '0;
                        cnt_next   = '0;
                        state_next = P_WIN_RD;
                    end
                end else if (int_last) begin
                    x_next     = '0;
                    y_next     = '0;
                    state_next = P_BORDER;
                end else begin
                    x_next     = int_x;
                    y_next     = int_y;
                    state_next = P_SCAN_RD;
                end
            end
            P_WIN_RD, P_WIN_ACC: begin
                if ((state_reg == P_WIN_RD) && inb) begin
                    mem_re     = 1'b1;
                    state_next = P_WIN_ACC;
                end else begin
                    sum_next   = sum_eff;
                    cnt_next   = cnt_eff;
                    state_next = P_WIN_RD;
                    if (!win_last) begin
                        if (row_end) begin
                            a_next = a_reg + S_W'(1);
                            b_next = -r_reg;
                        end else if (!ring_row && (b_reg == 1 - r_reg)) begin
                            b_next = r_reg - S_W'(1);
                        end else begin
                            b_next = b_reg + S_W'(1);
                        end
                    end else if (cnt_eff != '0) begin
                        state_next = P_DIV;
                    end else if (r2 > lim) begin
                        val_next   = thr.bias;
                        state_next = P_WR;
                    end else begin
                        r_next   = r2;
                        a_next   = -r2;
                        b_next   = -r2;
                        sum_next = '0;
                        cnt_next = '0;
                    end
                end
            end
            P_DIV: begin
                div_start  = 1'b1;
                state_next = P_DIV_WAIT;
            end
            P_DIV_WAIT: begin
                if (div_stat.done) begin
                    val_next   = quo[PIX_W-1:0];
                    state_next = P_WR;
                end
            end
            P_WR: begin
                mem_we    = 1'b1;
                mem_wdata = val_reg;
                if (val_reg <= thr.level) begin
                    qual_next = 1'b1;
                end
                if (int_last) begin
                    x_next     = '0;
                    y_next     = '0;
                    state_next = P_BORDER;
                end else begin
                    x_next     = int_x;
                    y_next     = int_y;
                    state_next = P_SCAN_RD;
                end
            end
            P_BORDER: begin
                mem_we = 1'b1;
                if (brd_last) begin
                    done_next  = 1'b1;
                    state_next = P_IDLE;
                end else if (x_reg == pc_reg - 1'b1) begin
                    x_next = '0;
                    y_next = y_reg + 1'b1;
                end else if ((y_reg != '0) && (y_reg != pr_reg - 1'b1) && (x_reg == '0)) begin
                    x_next = pc_reg - 1'b1;
                end else begin
                    x_next = x_reg + 1'b1;
                end
            end
            default: begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        pc_reg   <= pc_next;
        pr_reg   <= pr_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        r_reg    <= r_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        qual_reg <= qual_next;
        val_reg  <= val_next;
    end

    assign stat.busy = (state_reg != P_IDLE);
    assign stat.done = done_reg;

endmodule

[rtl/highlight_fill_filter.sv]
// Highlight fill filter top level: stream ports, configuration, load and readback.
// Depends on hff_pkg, hff_store, hff_pass and highlight_fill_filter_defines.svh.
//
// Usage: requests arrive on the s_ channel. s_tuser selects the action: a load
// writes s_tdata into the frame in raster order, and s_tlast on a load marks
// the final pixel and starts the in-place fill pass. A fetch returns the next
// pixel of the processed frame on the m_ channel, with m_tlast on the final
// pixel and m_tuser set when no processed frame is held.
// A load does not hold off the next request. A fetch reads the frame store, whose
// read data is registered, and then loads the output register; a load may be
// taken while a result waits. The fill pass reads every interior pixel twice and
// each in-bounds window cell once, runs at most one divide for each replaced
// pixel and clears each border pixel; no request is taken until it ends.
// Reset clears the pointers, the status and the output valid flag and restores
// the register defaults; the frame store holds no defined contents.
// While the receiver stalls, the result is held; one further fetch may be taken,
// and then no request is taken until the result is accepted.
`include "highlight_fill_filter_defines.svh"
module highlight_fill_filter
    import hff_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // pixel
    input  logic                  s_tlast,   // frame_end
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // out_pixel
    output logic                  m_tlast,   // out_last
    output logic                  m_tuser,   // no_frame
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int X_W    = $clog2(MAX_COLS + 1);
    localparam int Y_W    = $clog2(MAX_ROWS + 1);
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SIZE_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [DIM_CFG_W-1:0] cols_reg, rows_reg;
    logic [PIX_W-1:0]     level_reg, bias_reg;
    logic [SIZE_W-1:0]    lp_reg, lp_next;
    logic [SIZE_W-1:0]    fp_reg, fp_next;
    logic [SIZE_W-1:0]    held_reg, held_next;
    logic                 done_reg, done_next;
    logic                 pend_nf_reg, pend_nf_next;
    logic                 pend_last_reg, pend_last_next;
    logic                 mv_reg, mv_next;
    logic [PIX_W-1:0]     md_reg, md_next;
    logic                 ml_reg, ml_next;
    logic                 mu_reg, mu_next;

    logic [X_W-1:0]       pc_c;
    logic [Y_W-1:0]       pr_c;
    logic [SIZE_W-1:0]    size_c;
    logic                 in_acc, load, fetch, out_free;
    logic [SIZE_W-1:0]    fp_eff;
    logic                 top_we, top_re;
    logic [ADDR_W-1:0]    top_addr;
    hff_thr_t             thr;
    hff_pass_stat_t       pstat;
    logic                 p_we, p_re;
    logic [ADDR_W-1:0]    p_addr;
    logic [PIX_W-1:0]     p_wdata;
    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [PIX_W-1:0]     mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= RST_FRAME_COLS;
            rows_reg  <= RST_FRAME_ROWS;
            level_reg <= RST_HIGHLIGHT_LEVEL;
            bias_reg  <= RST_FILL_BIAS;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FRAME_COLS:      cols_reg  <= cfg_wdata[DIM_CFG_W-1:0];
                REG_FRAME_ROWS:      rows_reg  <= cfg_wdata[DIM_CFG_W-1:0];
                REG_HIGHLIGHT_LEVEL: level_reg <= cfg_wdata[PIX_W-1:0];
                REG_FILL_BIAS:       bias_reg  <= cfg_wdata[PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (32'(cols_reg) < MIN_DIM) begin
            pc_c = X_W'(MIN_DIM);
        end else if (32'(cols_reg) > MAX_COLS) begin
            pc_c = X_W'(MAX_COLS);
        end else begin
            pc_c = X_W'(cols_reg);
        end
        if (32'(rows_reg) < MIN_DIM) begin
            pr_c = Y_W'(MIN_DIM);
        end else if (32'(rows_reg) > MAX_ROWS) begin
            pr_c = Y_W'(MAX_ROWS);
        end else begin
            pr_c = Y_W'(rows_reg);
        end
        size_c = SIZE_W'({{Y_W{1'b0}}, pc_c} * {{X_W{1'b0}}, pr_c});
    end

    assign thr.level = level_reg;
    assign thr.bias  = bias_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign load     = in_acc && (s_tuser == ACT_LOAD);
    assign fetch    = in_acc && (s_tuser == ACT_FETCH);
    assign out_free = !mv_reg || m_tready;
    assign fp_eff   = (fp_reg >= held_reg) ? '0 : fp_reg;

    always_comb begin
        state_next     = state_reg;
        lp_next        = lp_reg;
        fp_next        = fp_reg;
        held_next      = held_reg;
        done_next      = done_reg;
        pend_nf_next   = pend_nf_reg;
        pend_last_next = pend_last_reg;
        mv_next        = mv_reg && !m_tready;
        md_next        = md_reg;
        ml_next        = ml_reg;
        mu_next        = mu_reg;
        top_we         = 1'b0;
        top_re         = 1'b0;
        top_addr       = lp_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (load) begin
                    if (lp_reg < size_c) begin
                        top_we  = 1'b1;
                        lp_next = lp_reg + 1'b1;
                    end
                    done_next = 1'b0;
                    fp_next   = '0;
                    if (s_tlast) begin
                        lp_next    = '0;
                        held_next  = size_c;
                        state_next = ST_PASS;
                    end
                end else if (fetch) begin
                    state_next = ST_FETCH;
                    if (done_reg) begin
                        top_re         = 1'b1;
                        top_addr       = fp_eff[ADDR_W-1:0];
                        pend_nf_next   = 1'b0;
                        pend_last_next = (fp_eff == held_reg - 1'b1);
                        if (fp_eff == held_reg - 1'b1) begin
                            done_next = 1'b0;
                            fp_next   = '0;
                        end else begin
                            fp_next = fp_eff + 1'b1;
                        end
                    end else begin
                        pend_nf_next   = 1'b1;
                        pend_last_next = 1'b0;
                    end
                end
            end
            ST_PASS: begin
                if (pstat.done) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    md_next    = pend_nf_reg ? '0 : mem_rdata;
                    ml_next    = pend_last_reg;
                    mu_next    = pend_nf_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lp_reg    <= '0;
            fp_reg    <= '0;
            held_reg  <= '0;
            done_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            lp_reg    <= lp_next;
            fp_reg    <= fp_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
            mv_reg    <= mv_next;
        end
        pend_nf_reg   <= pend_nf_next;
        pend_last_reg <= pend_last_next;
        md_reg        <= md_next;
        ml_reg        <= ml_next;
        mu_reg        <= mu_next;
    end

    hff_pass #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS),
        .X_W     (X_W),
        .Y_W     (Y_W),
        .ADDR_W  (ADDR_W)
    ) u_pass (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (load && s_tlast),
        .cols     (pc_c),
        .rows     (pr_c),
        .thr      (thr),
        .stat     (pstat),
        .mem_we   (p_we),
        .mem_re   (p_re),
        .mem_addr (p_addr),
        .mem_wdata(p_wdata),
        .mem_rdata(mem_rdata)
    );

    assign mem_we    = pstat.busy ? p_we : top_we;
    assign mem_re    = pstat.busy ? p_re : top_re;
    assign mem_waddr = pstat.busy ? p_addr : top_addr;
    assign mem_raddr = pstat.busy ? p_addr : top_addr;
    assign mem_wdata = pstat.busy ? p_wdata : s_tdata;

    hff_store #(
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    `HFF_ASSERT_NOW(a_pass_blocks_input, pstat.busy, !s_tready, "request taken during fill pass")
    `HFF_ASSERT_NEXT(a_pass_sets_frame, pstat.done, done_reg, "frame not marked after pass")
    `HFF_ASSERT_NOW(a_noframe_zero, m_tvalid && m_tuser, (m_tdata == '0) && !m_tlast,
                    "no-frame result carries data")
    `HFF_ASSERT_NEXT(a_last_clears, m_tvalid && m_tready && m_tlast && (state_reg != ST_PASS),
                     !done_reg || (state_reg == ST_PASS) || $past(load),
                     "frame still held after last pixel")

endmodule

[tb/tb_highlight_fill_filter.sv]
// Self-checking testbench for the highlight fill filter: loads frames, fetches them back
// and compares every result with a frame store kept by a scoreboard class.
// Depends on hff_pkg and the highlight_fill_filter RTL only.
module tb_highlight_fill_filter;
    import hff_pkg::*;

    localparam int TB_COLS = 512;
    localparam int TB_ROWS = 512;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
        logic             nof;
    } fetched_pixel_t;

    class fill_scoreboard;
        logic [PIX_W-1:0]     store [TB_COLS*TB_ROWS];
        logic [DIM_CFG_W-1:0] cols_reg = RST_FRAME_COLS;
        logic [DIM_CFG_W-1:0] rows_reg = RST_FRAME_ROWS;
        logic [PIX_W-1:0]     level = RST_HIGHLIGHT_LEVEL;
        logic [PIX_W-1:0]     bias = RST_FILL_BIAS;
        int unsigned          load_ptr = 0, fetch_ptr = 0, held = 0;
        bit                   done = 0;
        int                   pc, pr;
        longint               acc_sum;
        int                   acc_cnt;
        int                   errors = 0;
        int                   results = 0;
        fetched_pixel_t       pending [$];

        function int clamp(int v, int maxv);
            return v < MIN_DIM ? MIN_DIM : (v > maxv ? maxv : v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FRAME_COLS:      cols_reg = val;
                REG_FRAME_ROWS:      rows_reg = val;
                REG_HIGHLIGHT_LEVEL: level = val[PIX_W-1:0];
                REG_FILL_BIAS:       bias = val[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        function void probe(int y, int x);
            int v;
            if (y < 1 || y > pr - 1 || x < 1 || x > pc - 1) return;
            v = store[y*pc + x];
            if (v <= level) begin
                acc_sum += v;
                acc_cnt++;
            end
        endfunction

        function int fill_of(int y, int x, int qual);
            if (qual == 0) return bias;
            for (int r = 1; r <= pr + pc + 2; r += 2) begin
                acc_sum = 0;
                acc_cnt = 0;
                if (r == 1) begin
                    for (int a = -1; a <= 1; a++)
                        for (int b = -1; b <= 1; b++) probe(y + a, x + b);
                end else begin
                    for (int a = -r; a <= r; a++) begin
                        if ((a < 0 ? -a : a) >= r - 1) begin
                            for (int b = -r; b <= r; b++) probe(y + a, x + b);
                        end else begin
                            probe(y + a, x - r);
                            probe(y + a, x - r + 1);
                            probe(y + a, x + r - 1);
                            probe(y + a, x + r);
                        end
                    end
                end
                if (acc_cnt != 0) return int'((acc_sum + bias) / (acc_cnt + 1));
            end
            return bias;
        endfunction

        function void fill_frame();
            int qual = 0;
            int nv;
            pc = clamp(cols_reg, TB_COLS);
            pr = clamp(rows_reg, TB_ROWS);
            for (int y = 1; y < pr; y++)
                for (int x = 1; x < pc; x++)
                    if (store[y*pc + x] <= level) qual++;
            for (int y = 1; y < pr; y++)
                for (int x = 1; x < pc; x++)
                    if (store[y*pc + x] > level) begin
                        nv = fill_of(y, x, qual) & 8'hff;
                        store[y*pc + x] = PIX_W'(nv);
                        if (nv <= level) qual++;
                    end
            for (int x = 0; x < pc; x++) begin
                store[x] = 0;
                store[(pr - 1)*pc + x] = 0;
            end
            for (int y = 0; y < pr; y++) begin
                store[y*pc] = 0;
                store[y*pc + pc - 1] = 0;
            end
            held = pr * pc;
        endfunction

        function void note_request(logic act, logic [PIX_W-1:0] pix, logic fend);
            fetched_pixel_t e;
            if (act == ACT_LOAD) begin
                if (load_ptr < clamp(cols_reg, TB_COLS) * clamp(rows_reg, TB_ROWS)) begin
                    store[load_ptr] = pix;
                    load_ptr++;
                end
                done = 0;
                fetch_ptr = 0;
                if (fend) begin
                    fill_frame();
                    done = 1;
                    load_ptr = 0;
                end
                return;
            end
            if (!done || held == 0) begin
                e = '{pix: '0, last: 1'b0, nof: 1'b1};
            end else begin
                if (fetch_ptr >= held) fetch_ptr = 0;
                e.pix = store[fetch_ptr];
                e.nof = 1'b0;
                e.last = (fetch_ptr == held - 1);
                if (e.last) begin
                    done = 0;
                    fetch_ptr = 0;
                end else begin
                    fetch_ptr++;
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [PIX_W-1:0] pix, logic last, logic nof);
            fetched_pixel_t e;
            results++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result pixel=%0d last=%0b no_frame=%0b",
                         $time, pix, last, nof);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (pix !== e.pix) begin
                $display("%0t: out_pixel expected %0d actual %0d", $time, e.pix, pix);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: out_last expected %0b actual %0b", $time, e.last, last);
                errors++;
            end
            if (nof !== e.nof) begin
                $display("%0t: no_frame expected %0b actual %0b", $time, e.nof, nof);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata = '0;   // pixel
    logic                  s_tlast = 0;    // frame_end
    logic                  s_tuser = 0;    // action
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [PIX_W-1:0]      m_tdata;        // out_pixel
    logic                  m_tlast;        // out_last
    logic                  m_tuser;        // no_frame
    logic                  cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    fill_scoreboard sb = new();
    bit             no_idle = 0;
    int             stall_left = 0;
    int             requests = 0;
    int             frames = 0;

    highlight_fill_filter #(.MAX_COLS(TB_COLS), .MAX_ROWS(TB_ROWS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            stall_left <= gap_len();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    task automatic send_request(logic act, logic [PIX_W-1:0] pix, logic fend);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= pix;
        s_tlast <= fend;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(act, pix, fend);
        requests++;
    endtask

    // A fill pass may still run after the last result, so wait for the block to be ready too.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hot percentage sets how many loaded pixels are drawn from the highlight range.
    task automatic run_frame(int cols, int rows, int lvl, int bias, int hot, int extra,
                             int fetches, bit retune);
        int size;
        int v;
        drain();
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(cols));
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_HIGHLIGHT_LEVEL, CFG_DATA_W'(lvl));
        write_reg(REG_FILL_BIAS, CFG_DATA_W'(bias));
        size = sb.clamp(cols, TB_COLS) * sb.clamp(rows, TB_ROWS);
        for (int i = 0; i < size + extra; i++) begin
            if ($urandom_range(0, 99) < hot && lvl < 255) v = $urandom_range(lvl + 1, 255);
            else v = $urandom_range(0, 255);
            send_request(ACT_LOAD, PIX_W'(v), i == size + extra - 1);
        end
        frames++;
        for (int i = 0; i < fetches; i++) begin
            send_request(ACT_FETCH, PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            if (retune && i == 0) begin
                // Readback must keep the size latched at the pass.
                drain();
                write_reg(REG_FRAME_COLS, CFG_DATA_W'($urandom_range(3, 9)));
                write_reg(REG_FRAME_ROWS, CFG_DATA_W'($urandom_range(3, 9)));
            end
        end
    endtask

    initial begin
        int c, r, sz;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(ACT_FETCH, 8'hff, 1'b1);
        // Every interior pixel is a highlight, so no window ever qualifies.
        run_frame(3, 3, 0, 0, 100, 0, 10, 0);
        run_frame(3, 3, 0, 255, 100, 0, 9, 0);
        run_frame(4, 4, 255, 255, 0, 3, 16, 1);
        run_frame(5, 4, 100, 7, 90, 0, 6, 0);
        send_request(ACT_LOAD, 8'h00, 1'b0);
        send_request(ACT_FETCH, 8'h00, 1'b0);

        run_frame(0, 1, 200, 190, 20, 0, 9, 0);
        run_frame(2, 12, 150, 0, 30, 0, 36, 0);

        while (requests < 500) begin
            no_idle = ($urandom_range(0, 3) == 0);
            c = $urandom_range(0, 9) == 0 ? $urandom_range(0, 12) : $urandom_range(3, 7);
            r = $urandom_range(0, 9) == 0 ? $urandom_range(0, 12) : $urandom_range(3, 7);
            sz = sb.clamp(c, TB_COLS) * sb.clamp(r, TB_ROWS);
            run_frame(c, r, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 100), $urandom_range(0, 9) == 0 ? 2 : 0,
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, sz + 2) : sz,
                      $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 5) == 0) begin
                send_request(ACT_LOAD, PIX_W'($urandom_range(0, 255)), 1'b0);
                send_request(ACT_FETCH, 8'h00, 1'b0);
            end
        end
        no_idle = 0;
        drain();

        $display("Covered %0d frames, %0d requests and %0d checked results.",
                 frames, requests, sb.results);
        $display("Sizes from clamped small values up to 12 rows, all fill cases and aborted readbacks.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Timed out with %0d results outstanding.", sb.pending.size());
        $display("== FAIL ==");
        $finish;
    end
endmodule
